[rtl/core/smcd_pkg.sv]
// smcd_pkg: shared types, constants and the quarter-wave cosine table for the
// stepper microstep coil drive. No dependencies; used by every rtl/core file.
`timescale 1ns / 1ps

package smcd_pkg;

    // Electrical cycle geometry: 256 positions, 64 per full step
    localparam int unsigned CYCLE_STEPS  = 256;
    localparam int unsigned IDX_W        = 8;
    localparam logic [IDX_W-1:0] STEP_OFFSET   = 8'd64;
    localparam logic [IDX_W-1:0] HALF_CYCLE    = 8'd128;
    localparam logic [IDX_W-1:0] THREE_QUARTER = 8'd192;
    localparam logic [7:0] OFFSET_RESET  = 8'd64;

    // Configuration register map (word index)
    localparam logic REG_DRIVE_OFFSET = 1'b0;

    // Input transaction
    typedef struct packed {
        logic signed [7:0] torque;
        logic [7:0]        cycle_position;
    } t_drive_in;

    // Result transaction
    typedef struct packed {
        logic [7:0] vref_a;
        logic [7:0] vref_b;
        logic       a_positive;
        logic       a_negative;
        logic       b_positive;
        logic       b_negative;
    } t_drive_out;

    // Per-coil result between the scaling unit and the top level
    typedef struct packed {
        logic [7:0] vref;
        logic       positive;
        logic       negative;
    } t_coil;

    // Quarter wave of trunc(127*cos(2*pi*i/256)), i = 0..64
    function automatic logic [6:0] quarter_cos(input logic [6:0] q);
        logic [6:0] v;
        begin
            case (q)
                7'd0:  v = 7'd127; 7'd1:  v = 7'd126; 7'd2:  v = 7'd126;
                7'd3:  v = 7'd126; 7'd4:  v = 7'd126; 7'd5:  v = 7'd126;
                7'd6:  v = 7'd125; 7'd7:  v = 7'd125; 7'd8:  v = 7'd124;
                7'd9:  v = 7'd123; 7'd10: v = 7'd123; 7'd11: v = 7'd122;
                7'd12: v = 7'd121; 7'd13: v = 7'd120; 7'd14: v = 7'd119;
                7'd15: v = 7'd118; 7'd16: v = 7'd117; 7'd17: v = 7'd116;
                7'd18: v = 7'd114; 7'd19: v = 7'd113; 7'd20: v = 7'd112;
                7'd21: v = 7'd110; 7'd22: v = 7'd108; 7'd23: v = 7'd107;
                7'd24: v = 7'd105; 7'd25: v = 7'd103; 7'd26: v = 7'd102;
                7'd27: v = 7'd100; 7'd28: v = 7'd98;  7'd29: v = 7'd96;
                7'd30: v = 7'd94;  7'd31: v = 7'd91;  7'd32: v = 7'd89;
                7'd33: v = 7'd87;  7'd34: v = 7'd85;  7'd35: v = 7'd82;
                7'd36: v = 7'd80;  7'd37: v = 7'd78;  7'd38: v = 7'd75;
                7'd39: v = 7'd73;  7'd40: v = 7'd70;  7'd41: v = 7'd67;
                7'd42: v = 7'd65;  7'd43: v = 7'd62;  7'd44: v = 7'd59;
                7'd45: v = 7'd57;  7'd46: v = 7'd54;  7'd47: v = 7'd51;
                7'd48: v = 7'd48;  7'd49: v = 7'd45;  7'd50: v = 7'd42;
                7'd51: v = 7'd39;  7'd52: v = 7'd36;  7'd53: v = 7'd33;
                7'd54: v = 7'd30;  7'd55: v = 7'd27;  7'd56: v = 7'd24;
                7'd57: v = 7'd21;  7'd58: v = 7'd18;  7'd59: v = 7'd15;
                7'd60: v = 7'd12;  7'd61: v = 7'd9;   7'd62: v = 7'd6;
                7'd63: v = 7'd3;
                default: v = 7'd0;
            endcase
            return v;
        end
    endfunction

endpackage

[rtl/core/smcd_coil_scale.sv]
// smcd_coil_scale: one coil's cosine lookup (quarter wave unfolded by
// symmetry), magnitude scaling by torque and H-bridge enables.
// Depends on smcd_pkg.
`timescale 1ns / 1ps

module smcd_coil_scale (
    input  logic [7:0]     i_index,
    input  logic [7:0]     i_torque_mag,
    output smcd_pkg::t_coil o_coil
);

    logic [6:0]  phase_mag;
    logic        phase_neg;
    logic [6:0]  fold_idx;
    logic [13:0] product;

    // Fold the index into the first quarter and pick the sign
    always_comb begin
        if (i_index <= smcd_pkg::STEP_OFFSET) begin
            fold_idx  = i_index[6:0];
            phase_neg = 1'b0;
        end else if (i_index < smcd_pkg::HALF_CYCLE) begin
            fold_idx  = 7'(smcd_pkg::HALF_CYCLE - i_index);
            phase_neg = 1'b1;
        end else if (i_index <= smcd_pkg::THREE_QUARTER) begin
            fold_idx  = 7'(i_index - smcd_pkg::HALF_CYCLE);
            phase_neg = 1'b1;
        end else begin
            fold_idx  = 7'(9'd256 - {1'b0, i_index});
            phase_neg = 1'b0;
        end
    end

    assign phase_mag = smcd_pkg::quarter_cos(fold_idx);

    // Scale: |phase| * |torque| / 64, floored; peak 127*128 fits 14 bits
    assign product         = 14'(phase_mag) * 14'(i_torque_mag);
    assign o_coil.vref     = product[13:6];
    assign o_coil.positive = (phase_mag != 7'd0) && !phase_neg;
    assign o_coil.negative = (phase_mag != 7'd0) && phase_neg;

endmodule

[rtl/core/stepper_microstep_coil_drive_top.sv]
// stepper_microstep_coil_drive_top: two-stage coil drive pipeline with an
// APB-style register for the drive offset. Depends on smcd_pkg and
// smcd_coil_scale.
//
//  channel  | direction | handshake                   | payload
//  ---------+-----------+-----------------------------+---------------------
//  in       | sink      | i_in_valid / o_in_stall     | i_in_data (t_drive_in)
//  out      | source    | o_out_valid / i_out_stall   | o_out_data (t_drive_out)
//  config   | sink      | psel/penable/pwrite, pready | paddr, pwdata, prdata
//
// The pipeline has an input register, then lookup and scaling into the
// result register. A new transaction is taken every cycle unless an output
// stall fills both registers; each coil has a single 7x8 multiply between them.
// Reset (synchronous) empties both stages and loads drive_offset = 64.
// A stall on the output holds the result register; the input stage keeps
// accepting until it is also full.
`timescale 1ns / 1ps

module stepper_microstep_coil_drive_top (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  smcd_pkg::t_drive_in   i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output smcd_pkg::t_drive_out  o_out_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    logic [7:0]           r_drive_offset;
    logic                 r_s1_valid;
    smcd_pkg::t_drive_in  r_s1_data;
    logic                 r_out_valid;
    smcd_pkg::t_drive_out r_out_data;
    smcd_pkg::t_drive_out n_out_data;

    logic                 cfg_write;
    logic                 out_free;
    logic                 s1_advance;
    logic                 in_accept;
    logic                 torque_neg;
    logic [7:0]           torque_mag;
    logic [7:0]           idx_a;
    logic [7:0]           idx_b;
    smcd_pkg::t_coil      coil_a;
    smcd_pkg::t_coil      coil_b;

    // Register port: always ready, one word register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[2] == smcd_pkg::REG_DRIVE_OFFSET);
    assign prdata    = (paddr[2] == smcd_pkg::REG_DRIVE_OFFSET)
                       ? {24'd0, r_drive_offset} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drive_offset <= smcd_pkg::OFFSET_RESET;
        end else if (cfg_write) begin
            r_drive_offset <= pwdata[7:0];
        end
    end

    // Pipeline flow control
    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_advance = r_s1_valid && out_free;
    assign o_in_stall = r_s1_valid && !out_free;
    assign in_accept  = i_in_valid && !o_in_stall;

    // Hold the input transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_data <= i_in_data;
        end
    end

    // Direction picks the offset sign; zero torque counts as positive
    assign torque_neg = r_s1_data.torque[7];
    assign torque_mag = torque_neg ? 8'(-r_s1_data.torque) : 8'(r_s1_data.torque);
    assign idx_a      = torque_neg ? (r_s1_data.cycle_position - r_drive_offset)
                                   : (r_s1_data.cycle_position + r_drive_offset);
    assign idx_b      = idx_a - smcd_pkg::STEP_OFFSET;

    smcd_coil_scale u_coil_a (
        .i_index      (idx_a),
        .i_torque_mag (torque_mag),
        .o_coil       (coil_a)
    );

    smcd_coil_scale u_coil_b (
        .i_index      (idx_b),
        .i_torque_mag (torque_mag),
        .o_coil       (coil_b)
    );

    always_comb begin
        n_out_data.vref_a     = coil_a.vref;
        n_out_data.vref_b     = coil_b.vref;
        n_out_data.a_positive = coil_a.positive;
        n_out_data.a_negative = coil_a.negative;
        n_out_data.b_positive = coil_b.positive;
        n_out_data.b_negative = coil_b.negative;
    end

    // Advance the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_advance) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Coil A with no enable carries no current
    a_idle_coil_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_data.a_positive && !r_out_data.a_negative)
        |-> (r_out_data.vref_a == 8'd0))
        else $error("coil A idle with nonzero reference");

    // Never drive both bridge legs of a coil
    a_bridge_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_data.a_positive && r_out_data.a_negative)
                        && !(r_out_data.b_positive && r_out_data.b_negative))
        else $error("both bridge enables set");

    // A full pipeline under stall must push back on the input
    a_full_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && i_out_stall) |-> o_in_stall)
        else $error("input taken while pipeline full");

    // An accepted transaction lands in the input stage
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_s1_valid)
        else $error("accepted transaction lost");

    // A register write takes effect on the next cycle
    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_write |=> (r_drive_offset == $past(pwdata[7:0])))
        else $error("drive offset write lost");

endmodule
